// File: hdl/rde_pkg.sv
// rde_pkg: shared types and codes for the decode/execute stage
// opcode and function codes, control struct passed between stages
// no dependencies
package rde_pkg;

	// primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTIU = 6'h0b;
	localparam logic [5:0] OP_ANDI  = 6'h0c;
	localparam logic [5:0] OP_ORI   = 6'h0d;
	localparam logic [5:0] OP_LUI   = 6'h0f;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SW    = 6'h2b;

	// r-type function codes
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	localparam logic [4:0]  LINK_REG   = 5'd31;
	localparam logic [31:0] JUMP_REGION = 32'hf000_0000;
	localparam logic [31:0] BYTE_MASK   = 32'h0000_00ff;

	typedef enum logic [3:0] {
		ALU_ZERO  = 4'd0,
		ALU_AND   = 4'd1,
		ALU_ADD   = 4'd2,
		ALU_NOR   = 4'd3,
		ALU_OR    = 4'd4,
		ALU_SLTU  = 4'd5,
		ALU_SLL   = 4'd6,
		ALU_SRL   = 4'd7,
		ALU_SUB   = 4'd8,
		ALU_PASSB = 4'd9,
		ALU_LINK  = 4'd10
	} alu_op_t;

	typedef enum logic [2:0] {
		BR_NONE = 3'd0,
		BR_JR   = 3'd1,
		BR_JUMP = 3'd2,
		BR_EQ   = 3'd3,
		BR_NE   = 3'd4
	} br_kind_t;

	typedef enum logic [2:0] {
		MEM_NONE = 3'd0,
		MEM_LW   = 3'd1,
		MEM_LB   = 3'd2,
		MEM_SW   = 3'd3,
		MEM_SB   = 3'd4
	} mem_op_t;

	typedef struct packed {
		alu_op_t    alu_op;
		br_kind_t   br_kind;
		logic [4:0] shamt;
		logic [4:0] dest_reg;
		logic       dest_write;
		mem_op_t    mem_op;
	} ctrl_t;

endpackage

// File: hdl/rde_decode.sv
// rde_decode: instruction decode, second pipeline stage register
// depends on rde_pkg
module rde_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  logic [31:0]         instruction_s1,
	input  logic [31:0]         pc_s1,
	input  logic [31:0]         rs_data_s1,
	input  logic [31:0]         rt_data_s1,
	output logic                valid_s2,
	output rde_pkg::ctrl_t      ctrl_s2,
	output logic [31:0]         op_a_s2,
	output logic [31:0]         op_b_s2,
	output logic [31:0]         pc4_s2,
	output logic [31:0]         boff_s2,
	output logic [31:0]         jtarg_s2,
	output logic [31:0]         store_data_s2
);

	logic [5:0]     opcode;
	logic [5:0]     funct;
	logic [4:0]     rt;
	logic [4:0]     rd;
	logic [15:0]    imm;
	logic [31:0]    simm;
	logic [31:0]    zimm;
	rde_pkg::ctrl_t ctrl;
	logic [31:0]    op_b;
	logic [31:0]    store_data;

	assign opcode = instruction_s1[31:26];
	assign rt     = instruction_s1[20:16];
	assign rd     = instruction_s1[15:11];
	assign funct  = instruction_s1[5:0];
	assign imm    = instruction_s1[15:0];
	assign simm   = {{16{imm[15]}}, imm};
	assign zimm   = {16'h0000, imm};

	always_comb begin
		ctrl.alu_op     = rde_pkg::ALU_ZERO;
		ctrl.br_kind    = rde_pkg::BR_NONE;
		ctrl.shamt      = instruction_s1[10:6];
		ctrl.dest_reg   = '0;
		ctrl.dest_write = 1'b0;
		ctrl.mem_op     = rde_pkg::MEM_NONE;
		op_b            = rt_data_s1;
		store_data      = '0;
		unique case (opcode)
			rde_pkg::OP_RTYPE: begin
				if (funct == rde_pkg::FN_JR) begin
					ctrl.br_kind = rde_pkg::BR_JR;
				end else begin
					ctrl.dest_reg   = rd;
					ctrl.dest_write = 1'b1;
					unique case (funct)
						rde_pkg::FN_AND:  ctrl.alu_op = rde_pkg::ALU_AND;
						rde_pkg::FN_ADDU: ctrl.alu_op = rde_pkg::ALU_ADD;
						rde_pkg::FN_NOR:  ctrl.alu_op = rde_pkg::ALU_NOR;
						rde_pkg::FN_OR:   ctrl.alu_op = rde_pkg::ALU_OR;
						rde_pkg::FN_SLTU: ctrl.alu_op = rde_pkg::ALU_SLTU;
						rde_pkg::FN_SLL:  ctrl.alu_op = rde_pkg::ALU_SLL;
						rde_pkg::FN_SRL:  ctrl.alu_op = rde_pkg::ALU_SRL;
						rde_pkg::FN_SUBU: ctrl.alu_op = rde_pkg::ALU_SUB;
						default:          ctrl.alu_op = rde_pkg::ALU_ZERO;
					endcase
				end
			end
			rde_pkg::OP_ADDIU: begin
				ctrl.alu_op = rde_pkg::ALU_ADD;
				op_b = simm;
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
			end
			rde_pkg::OP_ANDI: begin
				ctrl.alu_op = rde_pkg::ALU_AND;
				op_b = zimm;
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
			end
			rde_pkg::OP_ORI: begin
				ctrl.alu_op = rde_pkg::ALU_OR;
				op_b = zimm;
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
			end
			rde_pkg::OP_SLTIU: begin
				ctrl.alu_op = rde_pkg::ALU_SLTU;
				op_b = simm;
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
			end
			rde_pkg::OP_LUI: begin
				ctrl.alu_op = rde_pkg::ALU_PASSB;
				op_b = {imm, 16'h0000};
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
			end
			rde_pkg::OP_BEQ: ctrl.br_kind = rde_pkg::BR_EQ;
			rde_pkg::OP_BNE: ctrl.br_kind = rde_pkg::BR_NE;
			rde_pkg::OP_J:   ctrl.br_kind = rde_pkg::BR_JUMP;
			rde_pkg::OP_JAL: begin
				ctrl.br_kind = rde_pkg::BR_JUMP;
				ctrl.alu_op = rde_pkg::ALU_LINK;
				ctrl.dest_reg = rde_pkg::LINK_REG;
				ctrl.dest_write = 1'b1;
			end
			rde_pkg::OP_LW: begin
				ctrl.alu_op = rde_pkg::ALU_ADD;
				op_b = simm;
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
				ctrl.mem_op = rde_pkg::MEM_LW;
			end
			rde_pkg::OP_LB: begin
				ctrl.alu_op = rde_pkg::ALU_ADD;
				op_b = simm;
				ctrl.dest_reg = rt;
				ctrl.dest_write = 1'b1;
				ctrl.mem_op = rde_pkg::MEM_LB;
			end
			rde_pkg::OP_SW: begin
				ctrl.alu_op = rde_pkg::ALU_ADD;
				op_b = simm;
				ctrl.mem_op = rde_pkg::MEM_SW;
				store_data = rt_data_s1;
			end
			rde_pkg::OP_SB: begin
				ctrl.alu_op = rde_pkg::ALU_ADD;
				op_b = simm;
				ctrl.mem_op = rde_pkg::MEM_SB;
				store_data = rt_data_s1 & rde_pkg::BYTE_MASK;
			end
			default: begin
				// unknown opcode behaves as a no-op
				ctrl.alu_op = rde_pkg::ALU_ZERO;
			end
		endcase
		// register zero is never written
		if (ctrl.dest_reg == 5'd0) begin
			ctrl.dest_write = 1'b0;
		end
		if (!ctrl.dest_write) begin
			ctrl.dest_reg = 5'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ctrl_s2       <= ctrl;
			op_a_s2       <= rs_data_s1;
			op_b_s2       <= op_b;
			pc4_s2        <= pc_s1 + 32'd4;
			boff_s2       <= {simm[29:0], 2'b00};
			jtarg_s2      <= (pc_s1 & rde_pkg::JUMP_REGION)
				| {4'h0, instruction_s1[25:0], 2'b00};
			store_data_s2 <= store_data;
		end
	end

endmodule

// File: hdl/rde_execute.sv
// rde_execute: alu, branch compare and target, result stage register
// depends on rde_pkg
module rde_execute (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  rde_pkg::ctrl_t ctrl_s2,
	input  logic [31:0]    op_a_s2,
	input  logic [31:0]    op_b_s2,
	input  logic [31:0]    pc4_s2,
	input  logic [31:0]    boff_s2,
	input  logic [31:0]    jtarg_s2,
	input  logic [31:0]    store_data_s2,
	output logic           valid_s3,
	output logic [31:0]    alu_result_s3,
	output logic [31:0]    branch_target_s3,
	output logic           redirect_s3,
	output logic [4:0]     dest_reg_s3,
	output logic           dest_write_s3,
	output logic [2:0]     mem_op_s3,
	output logic [31:0]    store_data_s3
);

	logic [31:0] alu;
	logic [31:0] target;
	logic        redirect;
	logic        equal;

	assign equal = (op_a_s2 == op_b_s2);

	always_comb begin
		unique case (ctrl_s2.alu_op)
			rde_pkg::ALU_AND:   alu = op_a_s2 & op_b_s2;
			rde_pkg::ALU_ADD:   alu = op_a_s2 + op_b_s2;
			rde_pkg::ALU_NOR:   alu = ~(op_a_s2 | op_b_s2);
			rde_pkg::ALU_OR:    alu = op_a_s2 | op_b_s2;
			rde_pkg::ALU_SLTU:  alu = {31'd0, op_a_s2 < op_b_s2};
			rde_pkg::ALU_SLL:   alu = op_b_s2 << ctrl_s2.shamt;
			rde_pkg::ALU_SRL:   alu = op_b_s2 >> ctrl_s2.shamt;
			rde_pkg::ALU_SUB:   alu = op_a_s2 - op_b_s2;
			rde_pkg::ALU_PASSB: alu = op_b_s2;
			rde_pkg::ALU_LINK:  alu = pc4_s2;
			default:            alu = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl_s2.br_kind)
			rde_pkg::BR_JR: begin
				target   = op_a_s2;
				redirect = 1'b1;
			end
			rde_pkg::BR_JUMP: begin
				target   = jtarg_s2;
				redirect = 1'b1;
			end
			rde_pkg::BR_EQ: begin
				target   = pc4_s2 + boff_s2;
				redirect = equal;
			end
			rde_pkg::BR_NE: begin
				target   = pc4_s2 + boff_s2;
				redirect = !equal;
			end
			default: begin
				target   = '0;
				redirect = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			alu_result_s3    <= alu;
			branch_target_s3 <= target;
			redirect_s3      <= redirect;
			dest_reg_s3      <= ctrl_s2.dest_reg;
			dest_write_s3    <= ctrl_s2.dest_write;
			mem_op_s3        <= ctrl_s2.mem_op;
			store_data_s3    <= store_data_s2;
		end
	end

endmodule

// File: hdl/risc_decode_execute_stage_top.sv
// risc_decode_execute_stage_top: three-stage decode/execute pipeline
// depends on rde_pkg, rde_decode, rde_execute
//
// channel   handshake          payload
// -------   ----------------   ------------------------------------------------
// input     start & !busy      instruction, pc, rs_data, rt_data
// result    done (one cycle)   alu_result, branch_target, redirect, dest_reg,
//                              dest_write, mem_op, store_data
//
// one item a cycle; each result is registered through every stage below, in order
// stages: input register, decode register, execute/result register
// busy is always low: the receiver cannot stall, so the pipeline never halts
// reset clears the valid bits only; no item is in flight after reset
module risc_decode_execute_stage_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instruction,
	input  logic [31:0] pc,
	input  logic [31:0] rs_data,
	input  logic [31:0] rt_data,
	output logic        done,
	output logic [31:0] alu_result,
	output logic [31:0] branch_target,
	output logic        redirect,
	output logic [4:0]  dest_reg,
	output logic        dest_write,
	output logic [2:0]  mem_op,
	output logic [31:0] store_data
);

	logic           valid_s1;
	logic [31:0]    instruction_s1;
	logic [31:0]    pc_s1;
	logic [31:0]    rs_data_s1;
	logic [31:0]    rt_data_s1;

	logic           valid_s2;
	rde_pkg::ctrl_t ctrl_s2;
	logic [31:0]    op_a_s2;
	logic [31:0]    op_b_s2;
	logic [31:0]    pc4_s2;
	logic [31:0]    boff_s2;
	logic [31:0]    jtarg_s2;
	logic [31:0]    store_data_s2;

	logic           accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instruction_s1 <= instruction;
			pc_s1          <= pc;
			rs_data_s1     <= rs_data;
			rt_data_s1     <= rt_data;
		end
	end

	rde_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.instruction_s1 (instruction_s1),
		.pc_s1          (pc_s1),
		.rs_data_s1     (rs_data_s1),
		.rt_data_s1     (rt_data_s1),
		.valid_s2       (valid_s2),
		.ctrl_s2        (ctrl_s2),
		.op_a_s2        (op_a_s2),
		.op_b_s2        (op_b_s2),
		.pc4_s2         (pc4_s2),
		.boff_s2        (boff_s2),
		.jtarg_s2       (jtarg_s2),
		.store_data_s2  (store_data_s2)
	);

	rde_execute u_execute (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s2         (valid_s2),
		.ctrl_s2          (ctrl_s2),
		.op_a_s2          (op_a_s2),
		.op_b_s2          (op_b_s2),
		.pc4_s2           (pc4_s2),
		.boff_s2          (boff_s2),
		.jtarg_s2         (jtarg_s2),
		.store_data_s2    (store_data_s2),
		.valid_s3         (done),
		.alu_result_s3    (alu_result),
		.branch_target_s3 (branch_target),
		.redirect_s3      (redirect),
		.dest_reg_s3      (dest_reg),
		.dest_write_s3    (dest_write),
		.mem_op_s3        (mem_op),
		.store_data_s3    (store_data)
	);

endmodule

// File: test/risc_decode_execute_stage_top_test.sv
`timescale 1ns / 1ps
// risc_decode_execute_stage_top_test: self-checking bench for the decode/execute stage
// directed instruction table, then random instruction streams under varying sender gaps
// depends on rde_pkg and risc_decode_execute_stage_top
module risc_decode_execute_stage_top_test;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 8;
	localparam int RANDOM_ITEMS = 1250;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [31:0]      alu_result;
		logic [31:0]      branch_target;
		logic             redirect;
		logic [4:0]       dest_reg;
		logic             dest_write;
		rde_pkg::mem_op_t mem_op;
		logic [31:0]      store_data;
	} exec_result_t;

	typedef struct {
		logic [31:0]  instruction;
		logic [31:0]  pc;
		logic [31:0]  rs_data;
		logic [31:0]  rt_data;
		logic         known;
		exec_result_t result;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] instruction;
	logic [31:0] pc;
	logic [31:0] rs_data;
	logic [31:0] rt_data;
	logic        done;
	logic [31:0] alu_result;
	logic [31:0] branch_target;
	logic        redirect;
	logic [4:0]  dest_reg;
	logic        dest_write;
	logic [2:0]  mem_op;
	logic [31:0] store_data;

	exec_result_t pending_results [$];
	exec_result_t staged_result;
	exec_result_t want_result;
	exec_result_t got_result;
	stim_row_t    insn_table [$];
	int           mismatch_count;
	int           quiet_cycles;
	int           phase_idle [3] = '{0, 75, 30};

	risc_decode_execute_stage_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.instruction  (instruction),
		.pc           (pc),
		.rs_data      (rs_data),
		.rt_data      (rt_data),
		.done         (done),
		.alu_result   (alu_result),
		.branch_target(branch_target),
		.redirect     (redirect),
		.dest_reg     (dest_reg),
		.dest_write   (dest_write),
		.mem_op       (mem_op),
		.store_data   (store_data)
	);

	always #5 clk = ~clk;

	function automatic exec_result_t execute_insn(input logic [31:0] insn,
		input logic [31:0] addr, input logic [31:0] a, input logic [31:0] b);
		exec_result_t r;
		logic [5:0]   opcode;
		logic [5:0]   funct;
		logic [4:0]   rt;
		logic [4:0]   rd;
		logic [4:0]   shamt;
		logic [31:0]  imm_z;
		logic [31:0]  imm_s;
		logic [31:0]  jump_tgt;
		logic [31:0]  br_tgt;
		opcode   = insn[31:26];
		rt       = insn[20:16];
		rd       = insn[15:11];
		shamt    = insn[10:6];
		funct    = insn[5:0];
		imm_z    = {16'h0000, insn[15:0]};
		imm_s    = {{16{insn[15]}}, insn[15:0]};
		jump_tgt = (addr & rde_pkg::JUMP_REGION) | {4'h0, insn[25:0], 2'b00};
		br_tgt   = addr + 32'd4 + {imm_s[29:0], 2'b00};
		r = '0;
		case (opcode)
		rde_pkg::OP_RTYPE: begin
			if (funct == rde_pkg::FN_JR) begin
				r.branch_target = a;
				r.redirect      = 1'b1;
			end else begin
				case (funct)
				rde_pkg::FN_AND:  r.alu_result = a & b;
				rde_pkg::FN_ADDU: r.alu_result = a + b;
				rde_pkg::FN_NOR:  r.alu_result = ~(a | b);
				rde_pkg::FN_OR:   r.alu_result = a | b;
				rde_pkg::FN_SLTU: r.alu_result = (a < b) ? 32'd1 : 32'd0;
				rde_pkg::FN_SLL:  r.alu_result = b << shamt;
				rde_pkg::FN_SRL:  r.alu_result = b >> shamt;
				rde_pkg::FN_SUBU: r.alu_result = a - b;
				default:          r.alu_result = '0;
				endcase
				r.dest_reg   = rd;
				r.dest_write = 1'b1;
			end
		end
		rde_pkg::OP_ADDIU: begin
			r.alu_result = a + imm_s;
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
		end
		rde_pkg::OP_ANDI: begin
			r.alu_result = a & imm_z;
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
		end
		rde_pkg::OP_ORI: begin
			r.alu_result = a | imm_z;
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
		end
		rde_pkg::OP_SLTIU: begin
			// immediate is sign-extended, comparison is unsigned
			r.alu_result = (a < imm_s) ? 32'd1 : 32'd0;
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
		end
		rde_pkg::OP_LUI: begin
			r.alu_result = {insn[15:0], 16'h0000};
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
		end
		rde_pkg::OP_BEQ: begin
			r.branch_target = br_tgt;
			r.redirect      = (a == b);
		end
		rde_pkg::OP_BNE: begin
			r.branch_target = br_tgt;
			r.redirect      = (a != b);
		end
		rde_pkg::OP_J: begin
			r.branch_target = jump_tgt;
			r.redirect      = 1'b1;
		end
		rde_pkg::OP_JAL: begin
			r.branch_target = jump_tgt;
			r.redirect      = 1'b1;
			r.alu_result    = addr + 32'd4;
			r.dest_reg      = rde_pkg::LINK_REG;
			r.dest_write    = 1'b1;
		end
		rde_pkg::OP_LW: begin
			r.alu_result = a + imm_s;
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
			r.mem_op     = rde_pkg::MEM_LW;
		end
		rde_pkg::OP_LB: begin
			r.alu_result = a + imm_s;
			r.dest_reg   = rt;
			r.dest_write = 1'b1;
			r.mem_op     = rde_pkg::MEM_LB;
		end
		rde_pkg::OP_SW: begin
			r.alu_result = a + imm_s;
			r.mem_op     = rde_pkg::MEM_SW;
			r.store_data = b;
		end
		rde_pkg::OP_SB: begin
			r.alu_result = a + imm_s;
			r.mem_op     = rde_pkg::MEM_SB;
			r.store_data = b & rde_pkg::BYTE_MASK;
		end
		default: ;
		endcase
		// register 0 is never written
		if (r.dest_reg == 5'd0)
			r.dest_write = 1'b0;
		if (!r.dest_write)
			r.dest_reg = '0;
		return r;
	endfunction

	function automatic logic [31:0] enc_r(input logic [5:0] funct, input logic [4:0] rs,
		input logic [4:0] rt, input logic [4:0] rd, input logic [4:0] shamt);
		return {rde_pkg::OP_RTYPE, rs, rt, rd, shamt, funct};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] opcode, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {opcode, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_j(input logic [5:0] opcode, input logic [25:0] target);
		return {opcode, target};
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
		0:       return 32'h0000_0000;
		1:       return 32'hffff_ffff;
		2:       return 32'h8000_0000;
		3:       return 32'h7fff_ffff;
		default: return $urandom;
		endcase
	endfunction

	task automatic add_row(input logic [31:0] insn, input logic [31:0] addr,
		input logic [31:0] a, input logic [31:0] b);
		stim_row_t row;
		row.instruction = insn;
		row.pc          = addr;
		row.rs_data     = a;
		row.rt_data     = b;
		row.known       = 1'b0;
		row.result      = '0;
		insn_table.push_back(row);
	endtask

	task automatic add_known(input logic [31:0] insn, input logic [31:0] addr,
		input logic [31:0] a, input logic [31:0] b, input exec_result_t res);
		stim_row_t row;
		row.instruction = insn;
		row.pc          = addr;
		row.rs_data     = a;
		row.rt_data     = b;
		row.known       = 1'b1;
		row.result      = res;
		insn_table.push_back(row);
	endtask

	// mostly well-formed instructions with random fields, a few raw words
	task automatic random_item(output logic [31:0] insn, output logic [31:0] addr,
		output logic [31:0] a, output logic [31:0] b);
		logic [5:0] opcode;
		insn   = $urandom;
		addr   = pick_word();
		a      = pick_word();
		b      = pick_word();
		opcode = insn[31:26];
		case ($urandom_range(19))
		0, 1, 2, 3, 4, 5: opcode = rde_pkg::OP_RTYPE;
		6:  opcode = rde_pkg::OP_J;
		7:  opcode = rde_pkg::OP_JAL;
		8:  opcode = rde_pkg::OP_BEQ;
		9:  opcode = rde_pkg::OP_BNE;
		10: opcode = rde_pkg::OP_ADDIU;
		11: opcode = rde_pkg::OP_SLTIU;
		12: opcode = rde_pkg::OP_ANDI;
		13: opcode = rde_pkg::OP_ORI;
		14: opcode = rde_pkg::OP_LUI;
		15: opcode = rde_pkg::OP_LB;
		16: opcode = rde_pkg::OP_LW;
		17: opcode = rde_pkg::OP_SB;
		18: opcode = rde_pkg::OP_SW;
		default: ;
		endcase
		insn[31:26] = opcode;
		if (opcode == rde_pkg::OP_RTYPE) begin
			case ($urandom_range(9))
			0: insn[5:0] = rde_pkg::FN_SLL;
			1: insn[5:0] = rde_pkg::FN_SRL;
			2: insn[5:0] = rde_pkg::FN_JR;
			3: insn[5:0] = rde_pkg::FN_ADDU;
			4: insn[5:0] = rde_pkg::FN_SUBU;
			5: insn[5:0] = rde_pkg::FN_AND;
			6: insn[5:0] = rde_pkg::FN_OR;
			7: insn[5:0] = rde_pkg::FN_NOR;
			8: insn[5:0] = rde_pkg::FN_SLTU;
			default: ;
			endcase
		end
		// give branches and compares a fair share of equal operands
		if ($urandom_range(3) == 0)
			b = a;
	endtask

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input logic [31:0] insn, input logic [31:0] addr,
		input logic [31:0] a, input logic [31:0] b, input exec_result_t res,
		input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start       <= 1'b0;
			instruction <= $urandom;
			pc          <= $urandom;
			rs_data     <= $urandom;
			rt_data     <= $urandom;
			@(negedge clk);
		end
		start         <= 1'b1;
		instruction   <= insn;
		pc            <= addr;
		rs_data       <= a;
		rt_data       <= b;
		staged_result = res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// result checking, item capture and watchdog share one process so queue order is fixed
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				got_result = '{alu_result, branch_target, redirect, dest_reg, dest_write,
					rde_pkg::mem_op_t'(mem_op), store_data};
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected: alu %h tgt %h rd %b dst %0d wr %b mem %0d sd %h",
							alu_result, branch_target, redirect, dest_reg, dest_write,
							mem_op, store_data);
				end else begin
					want_result = pending_results.pop_front();
					if (got_result !== want_result) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display("exp: alu %h tgt %h rd %b dst %0d wr %b mem %0d sd %h",
								want_result.alu_result, want_result.branch_target,
								want_result.redirect, want_result.dest_reg,
								want_result.dest_write, want_result.mem_op,
								want_result.store_data);
							$display("got: alu %h tgt %h rd %b dst %0d wr %b mem %0d sd %h",
								alu_result, branch_target, redirect, dest_reg, dest_write,
								mem_op, store_data);
						end
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(staged_result);
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL risc_decode_execute_stage_top");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0]  insn;
		logic [31:0]  addr;
		logic [31:0]  a;
		logic [31:0]  b;
		exec_result_t res;
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		instruction    = '0;
		pc             = '0;
		rs_data        = '0;
		rt_data        = '0;
		staged_result  = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;

		// unknown opcode acts as a no-op
		add_known(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			'{32'h0, 32'h0, 1'b0, 5'd0, 1'b0, rde_pkg::MEM_NONE, 32'h0});
		// write to register 0 suppressed
		add_known(enc_r(rde_pkg::FN_ADDU, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'd1, 32'd2,
			'{32'd3, 32'h0, 1'b0, 5'd0, 1'b0, rde_pkg::MEM_NONE, 32'h0});
		// unknown function still writes rd with zero
		add_known(enc_r(6'h3f, 5'd1, 5'd2, 5'd5, 5'd0), 32'h0, 32'hffff_ffff, 32'hffff_ffff,
			'{32'h0, 32'h0, 1'b0, 5'd5, 1'b1, rde_pkg::MEM_NONE, 32'h0});
		add_known(enc_r(rde_pkg::FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 32'h0, 32'hffff_ffff, 32'h0,
			'{32'h0, 32'hffff_ffff, 1'b1, 5'd0, 1'b0, rde_pkg::MEM_NONE, 32'h0});
		add_known(enc_j(rde_pkg::OP_J, 26'h3ff_ffff), 32'hffff_fffc, 32'h0, 32'h0,
			'{32'h0, 32'hffff_fffc, 1'b1, 5'd0, 1'b0, rde_pkg::MEM_NONE, 32'h0});
		// link address wraps at the top of memory
		add_known(enc_j(rde_pkg::OP_JAL, 26'h0), 32'hffff_fffc, 32'h0, 32'h0,
			'{32'h0, 32'hf000_0000, 1'b1, 5'd31, 1'b1, rde_pkg::MEM_NONE, 32'h0});
		add_known(enc_i(rde_pkg::OP_LUI, 5'd0, 5'd31, 16'hffff), 32'h0, 32'h0, 32'h0,
			'{32'hffff_0000, 32'h0, 1'b0, 5'd31, 1'b1, rde_pkg::MEM_NONE, 32'h0});
		add_known(enc_i(rde_pkg::OP_SB, 5'd0, 5'd1, 16'h0), 32'h0, 32'h0, 32'hffff_ffff,
			'{32'h0, 32'h0, 1'b0, 5'd0, 1'b0, rde_pkg::MEM_SB, 32'h0000_00ff});
		add_known(enc_i(rde_pkg::OP_SW, 5'd0, 5'd1, 16'h0), 32'h0, 32'h0, 32'hffff_ffff,
			'{32'h0, 32'h0, 1'b0, 5'd0, 1'b0, rde_pkg::MEM_SW, 32'hffff_ffff});
		add_known(enc_i(rde_pkg::OP_LW, 5'd0, 5'd0, 16'h4), 32'h0, 32'h0, 32'h0,
			'{32'd4, 32'h0, 1'b0, 5'd0, 1'b0, rde_pkg::MEM_LW, 32'h0});
		add_row(enc_r(rde_pkg::FN_AND, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0, 32'hffff_0000,
			32'h0f0f_0f0f);
		add_row(enc_r(rde_pkg::FN_NOR, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0, 32'h0, 32'h0);
		add_row(enc_r(rde_pkg::FN_OR, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0, 32'h8000_0000,
			32'h0000_0001);
		add_row(enc_r(rde_pkg::FN_SLTU, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0, 32'h1, 32'hffff_ffff);
		add_row(enc_r(rde_pkg::FN_SLTU, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0, 32'hffff_ffff, 32'h1);
		add_row(enc_r(rde_pkg::FN_SLL, 5'd0, 5'd2, 5'd4, 5'd31), 32'h0, 32'h0, 32'h1);
		add_row(enc_r(rde_pkg::FN_SRL, 5'd0, 5'd2, 5'd4, 5'd31), 32'h0, 32'h0, 32'h8000_0000);
		add_row(enc_r(rde_pkg::FN_SUBU, 5'd1, 5'd2, 5'd31, 5'd0), 32'h0, 32'h0, 32'h1);
		add_row(enc_i(rde_pkg::OP_ADDIU, 5'd1, 5'd9, 16'h8000), 32'h0, 32'h0, 32'h0);
		add_row(enc_i(rde_pkg::OP_ANDI, 5'd1, 5'd10, 16'hffff), 32'h0, 32'hffff_ffff, 32'h0);
		add_row(enc_i(rde_pkg::OP_ORI, 5'd1, 5'd11, 16'h8000), 32'h0, 32'h0, 32'h0);
		add_row(enc_i(rde_pkg::OP_SLTIU, 5'd1, 5'd12, 16'hffff), 32'h0, 32'hffff_fffe, 32'h0);
		add_row(enc_i(rde_pkg::OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0, 32'd5, 32'd5);
		add_row(enc_i(rde_pkg::OP_BEQ, 5'd1, 5'd2, 16'h7fff), 32'hffff_fff0, 32'd5, 32'd6);
		add_row(enc_i(rde_pkg::OP_BNE, 5'd1, 5'd2, 16'hffff), 32'h0000_1000, 32'd5, 32'd6);
		add_row(enc_i(rde_pkg::OP_BNE, 5'd1, 5'd2, 16'h0001), 32'h0000_1000, 32'd7, 32'd7);
		add_row(enc_i(rde_pkg::OP_LB, 5'd1, 5'd31, 16'hffff), 32'h0, 32'h0, 32'h0);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (insn_table[i]) begin
			if (insn_table[i].known)
				res = insn_table[i].result;
			else
				res = execute_insn(insn_table[i].instruction, insn_table[i].pc,
					insn_table[i].rs_data, insn_table[i].rt_data);
			send_item(insn_table[i].instruction, insn_table[i].pc, insn_table[i].rs_data,
				insn_table[i].rt_data, res, 30);
		end
		drain();

		// back-to-back, heavy sender gaps, light sender gaps; pipeline emptied between
		for (int p = 0; p < 3; p++) begin
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				random_item(insn, addr, a, b);
				send_item(insn, addr, a, b, execute_insn(insn, addr, a, b), phase_idle[p]);
			end
			drain();
		end

		repeat (SETTLE_TICKS) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS risc_decode_execute_stage_top");
		else
			$display("FAIL risc_decode_execute_stage_top");
		$finish;
	end

endmodule
